// File: sv/gcbs_pkg.sv
`default_nettype none
package gcbs_pkg;

	localparam int unsigned DEF_GRID_X      = 16;
	localparam int unsigned DEF_GRID_Y      = 16;
	localparam int unsigned DEF_GRID_Z      = 16;
	localparam int unsigned DEF_DENSE_SLOTS = 4;
	localparam int unsigned DEF_CHUNK_LEN   = 8;
	localparam int unsigned DEF_POOL_CHUNKS = 256;

	localparam int unsigned CNT_W   = 12;
	localparam int unsigned ID_W    = 32;
	localparam int unsigned IDX_W   = 12;
	localparam int unsigned COORD_W = 4;
	localparam int unsigned IN_W    = 64;
	localparam int unsigned OUT_W   = 48;

	typedef enum logic [1:0] {
		CMD_APPEND    = 2'd0,
		CMD_CLEAR     = 2'd1,
		CMD_READ      = 2'd2,
		CMD_CLEAR_ALL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_POOL_FULL = 2'd1,
		STAT_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_EXEC,
		S_LINK,
		S_WALK,
		S_WALK_WAIT,
		S_DATA,
		S_OUT,
		S_SWEEP
	} state_t;

	// Coordinate wrap into a grid dimension; independent range compares only.
	function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] v,
			input int unsigned dim);
		logic [COORD_W-1:0] r;
		r = v;
		if (dim < 16) begin
			for (int unsigned k = 0; k < 16; k++) begin
				if (32'(v) >= k * dim && 32'(v) < (k + 1) * dim) begin
					r = COORD_W'(32'(v) - k * dim);
				end
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/gcbs_ram.sv
`default_nettype none
module gcbs_ram #(
	parameter int unsigned W = 32,
	parameter int unsigned D = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0]   waddr,
	input  wire logic [W-1:0]                         wdata,
	input  wire logic                                 re,
	input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0]   raddr,
	output logic      [W-1:0]                         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: sv/gcbs_link_store.sv
`default_nettype none
module gcbs_link_store #(
	parameter int unsigned POOL = 256,
	parameter int unsigned CH_W = 8,
	parameter int unsigned LNK_W = 9
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clr_all,
	input  wire logic             re,
	input  wire logic [CH_W-1:0]  raddr,
	output logic      [LNK_W-1:0] rdata,
	input  wire logic             we,
	input  wire logic [CH_W-1:0]  waddr,
	input  wire logic [LNK_W-1:0] wdata
);
	logic [LNK_W-1:0] mem [POOL];
	logic [POOL-1:0]  valid_q;
	logic [LNK_W-1:0] mem_q;
	logic             vld_q;
	logic [CH_W-1:0]  addr_q;

	// An entry never written since reset or clear all reads as the next chunk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr_all) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			mem_q  <= mem[raddr];
			vld_q  <= valid_q[raddr];
			addr_q <= raddr;
		end
	end

	assign rdata = vld_q ? mem_q : LNK_W'(addr_q) + LNK_W'(1);
endmodule
`default_nettype wire

// File: sv/grid_cell_bin_store_unit.sv
`default_nettype none
// Binning store for a 3-D grid of cells. Each cell holds a count, DENSE_SLOTS dense
// ids and a chain of CHUNK_LEN-id chunks from a shared pool of POOL_CHUNKS chunks.
// One item is in flight at a time; each command passes an accept state, a memory
// read state, an execute state and an output state. An append that links a new chunk
// behind an existing one also passes a link state, a read from the dense slots passes
// a data state, a read from a chunk passes a walk state and a data state plus a walk
// and a walk-wait state per chunk link followed, and clear all is followed by a
// count-memory clearing pass over all GRID_X*GRID_Y*GRID_Z cells. The same clearing pass
// runs once after reset; no item is accepted during it. A result that is not yet taken
// holds the block in the output state of the next command. The count, chunk link and
// data memories each have a registered read.
module grid_cell_bin_store_unit
	import gcbs_pkg::*;
#(
	parameter int unsigned GRID_X      = DEF_GRID_X,
	parameter int unsigned GRID_Y      = DEF_GRID_Y,
	parameter int unsigned GRID_Z      = DEF_GRID_Z,
	parameter int unsigned DENSE_SLOTS = DEF_DENSE_SLOTS,
	parameter int unsigned CHUNK_LEN   = DEF_CHUNK_LEN,
	parameter int unsigned POOL_CHUNKS = DEF_POOL_CHUNKS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// cmd[1:0], cell_x[5:2], cell_y[9:6], cell_z[13:10], id_in[45:14],
	// elem_index[57:46], zero[63:58]
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// status[1:0], cell_count[13:2], id_out[45:14]
	output logic      [OUT_W-1:0] m_tdata
);
	localparam int unsigned NCELLS   = GRID_X * GRID_Y * GRID_Z;
	localparam int unsigned CELL_W   = NCELLS > 1 ? $clog2(NCELLS) : 1;
	localparam int unsigned DENSE_D  = NCELLS * DENSE_SLOTS;
	localparam int unsigned DENSE_AW = DENSE_D > 1 ? $clog2(DENSE_D) : 1;
	localparam int unsigned POOL_D   = POOL_CHUNKS * CHUNK_LEN;
	localparam int unsigned POOL_AW  = POOL_D > 1 ? $clog2(POOL_D) : 1;
	localparam int unsigned CH_W     = POOL_CHUNKS > 1 ? $clog2(POOL_CHUNKS) : 1;
	localparam int unsigned LNK_W    = $clog2(POOL_CHUNKS + 1);
	localparam int unsigned FILL_W   = $clog2(CHUNK_LEN + 1);
	localparam int unsigned META_W   = 2 * CH_W + FILL_W;
	localparam logic [LNK_W-1:0] NIL = LNK_W'(POOL_CHUNKS);

	state_t state_q, state_d;

	cmd_t              cmd_q;
	logic [CELL_W-1:0] cell_q;
	logic [ID_W-1:0]   id_q;
	logic [IDX_W-1:0]  idx_q;
	logic [LNK_W-1:0]  free_q;
	logic [LNK_W-1:0]  ch_q;
	logic [IDX_W-1:0]  rem_q;
	logic [CH_W-1:0]   nc_q;
	logic [CH_W-1:0]   last_q;
	logic              sel_pool_q;
	logic              sweep_pend_q;
	logic [CELL_W-1:0] sweep_q;
	status_t           res_status_q;
	logic [CNT_W-1:0]  res_count_q;
	logic [ID_W-1:0]   res_id_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	// Memory ports.
	logic                cnt_we, cnt_re;
	logic [CELL_W-1:0]   cnt_waddr;
	logic [CNT_W-1:0]    cnt_wdata, cnt_rd;
	logic                meta_we, meta_re;
	logic [META_W-1:0]   meta_wdata, meta_rd;
	logic                dense_we, dense_re;
	logic [DENSE_AW-1:0] dense_waddr, dense_raddr;
	logic [ID_W-1:0]     dense_rd;
	logic                pool_we, pool_re;
	logic [POOL_AW-1:0]  pool_waddr, pool_raddr;
	logic [ID_W-1:0]     pool_rd;
	logic                lnk_we, lnk_re, lnk_clr;
	logic [CH_W-1:0]     lnk_waddr, lnk_raddr;
	logic [LNK_W-1:0]    lnk_wdata, lnk_rd;

	logic [CH_W-1:0]   first_rd, last_rd;
	logic [FILL_W-1:0] fill_rd;
	logic [CH_W-1:0]   nc;
	logic              need_chunk, out_free;
	logic [31:0]       cell_full;
	logic [COORD_W-1:0] xm, ym, zm;

	assign {first_rd, last_rd, fill_rd} = meta_rd;
	assign nc = free_q[CH_W-1:0];
	assign need_chunk = (cnt_rd == CNT_W'(DENSE_SLOTS)) || (fill_rd == FILL_W'(CHUNK_LEN));
	assign out_free = !m_tvalid_q || m_tready;

	assign xm = wrap_coord(s_tdata[5:2], GRID_X);
	assign ym = wrap_coord(s_tdata[9:6], GRID_Y);
	assign zm = wrap_coord(s_tdata[13:10], GRID_Z);
	assign cell_full = (32'(xm) * GRID_Y + 32'(ym)) * GRID_Z + 32'(zm);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	gcbs_ram #(.W(CNT_W), .D(NCELLS)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.re(cnt_re), .raddr(cell_q), .rdata(cnt_rd)
	);

	gcbs_ram #(.W(META_W), .D(NCELLS)) u_meta (
		.clk(clk), .we(meta_we), .waddr(cell_q), .wdata(meta_wdata),
		.re(meta_re), .raddr(cell_q), .rdata(meta_rd)
	);

	gcbs_ram #(.W(ID_W), .D(DENSE_D)) u_dense (
		.clk(clk), .we(dense_we), .waddr(dense_waddr), .wdata(id_q),
		.re(dense_re), .raddr(dense_raddr), .rdata(dense_rd)
	);

	gcbs_ram #(.W(ID_W), .D(POOL_D)) u_pool (
		.clk(clk), .we(pool_we), .waddr(pool_waddr), .wdata(id_q),
		.re(pool_re), .raddr(pool_raddr), .rdata(pool_rd)
	);

	gcbs_link_store #(.POOL(POOL_CHUNKS), .CH_W(CH_W), .LNK_W(LNK_W)) u_links (
		.clk(clk), .arst_n(arst_n), .clr_all(lnk_clr),
		.re(lnk_re), .raddr(lnk_raddr), .rdata(lnk_rd),
		.we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_RD;
				end
			end
			S_RD: state_d = S_EXEC;
			S_EXEC: begin
				state_d = S_OUT;
				case (cmd_q)
					CMD_APPEND: begin
						if (cnt_rd > CNT_W'(DENSE_SLOTS) && need_chunk && free_q < NIL) begin
							state_d = S_LINK;
						end
					end
					CMD_READ: begin
						if (IDX_W'(idx_q) < cnt_rd) begin
							state_d = (idx_q < IDX_W'(DENSE_SLOTS)) ? S_DATA : S_WALK;
						end
					end
					default: state_d = S_OUT;
				endcase
			end
			S_LINK: state_d = S_OUT;
			S_WALK: begin
				if (ch_q >= NIL) begin
					state_d = S_OUT;
				end else if (rem_q >= IDX_W'(CHUNK_LEN)) begin
					state_d = S_WALK_WAIT;
				end else begin
					state_d = S_DATA;
				end
			end
			S_WALK_WAIT: state_d = S_WALK;
			S_DATA: state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = sweep_pend_q ? S_SWEEP : S_IDLE;
				end
			end
			S_SWEEP: begin
				if (sweep_q == CELL_W'(NCELLS - 1)) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cnt_re      = (state_q == S_RD);
		meta_re     = (state_q == S_RD);
		lnk_re      = 1'b0;
		lnk_raddr   = nc;
		cnt_we      = 1'b0;
		cnt_waddr   = cell_q;
		cnt_wdata   = cnt_rd + CNT_W'(1);
		meta_we     = 1'b0;
		meta_wdata  = {first_rd, last_rd, fill_rd + FILL_W'(1)};
		dense_we    = 1'b0;
		dense_waddr = DENSE_AW'(32'(cell_q) * DENSE_SLOTS + 32'(cnt_rd));
		dense_re    = 1'b0;
		dense_raddr = DENSE_AW'(32'(cell_q) * DENSE_SLOTS + 32'(idx_q));
		pool_we     = 1'b0;
		pool_waddr  = POOL_AW'(32'(last_rd) * CHUNK_LEN + 32'(fill_rd));
		pool_re     = 1'b0;
		pool_raddr  = POOL_AW'(32'(ch_q) * CHUNK_LEN + 32'(rem_q));
		lnk_we      = 1'b0;
		lnk_waddr   = nc;
		lnk_wdata   = NIL;
		lnk_clr     = 1'b0;
		case (state_q)
			S_RD: lnk_re = 1'b1;
			S_EXEC: begin
				case (cmd_q)
					CMD_APPEND: begin
						if (cnt_rd < CNT_W'(DENSE_SLOTS)) begin
							dense_we = 1'b1;
							cnt_we   = 1'b1;
						end else if (!need_chunk) begin
							pool_we = 1'b1;
							meta_we = 1'b1;
							cnt_we  = 1'b1;
						end else if (free_q < NIL) begin
							// Take the free-list head as the cell's new last chunk.
							lnk_we     = 1'b1;
							pool_we    = 1'b1;
							pool_waddr = POOL_AW'(32'(nc) * CHUNK_LEN);
							meta_we    = 1'b1;
							meta_wdata = {(cnt_rd == CNT_W'(DENSE_SLOTS)) ? nc : first_rd,
								nc, FILL_W'(1)};
							cnt_we     = 1'b1;
						end
					end
					CMD_CLEAR: begin
						cnt_we    = 1'b1;
						cnt_wdata = '0;
						if (cnt_rd > CNT_W'(DENSE_SLOTS)) begin
							lnk_we    = 1'b1;
							lnk_waddr = last_rd;
							lnk_wdata = free_q;
						end
					end
					CMD_READ: begin
						dense_re = (idx_q < cnt_rd) && (idx_q < IDX_W'(DENSE_SLOTS));
					end
					default: lnk_clr = 1'b1;
				endcase
			end
			S_LINK: begin
				lnk_we    = 1'b1;
				lnk_waddr = last_q;
				lnk_wdata = LNK_W'(nc_q);
			end
			S_WALK: begin
				if (ch_q < NIL) begin
					if (rem_q >= IDX_W'(CHUNK_LEN)) begin
						lnk_re    = 1'b1;
						lnk_raddr = ch_q[CH_W-1:0];
					end else begin
						pool_re = 1'b1;
					end
				end
			end
			S_SWEEP: begin
				cnt_we    = 1'b1;
				cnt_waddr = sweep_q;
				cnt_wdata = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			free_q       <= '0;
			sweep_q      <= '0;
			sweep_pend_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EXEC) begin
				if (cmd_q == CMD_APPEND && cnt_rd >= CNT_W'(DENSE_SLOTS) && need_chunk
						&& free_q < NIL) begin
					free_q <= lnk_rd;
				end else if (cmd_q == CMD_CLEAR && cnt_rd > CNT_W'(DENSE_SLOTS)) begin
					free_q <= LNK_W'(first_rd);
				end else if (cmd_q == CMD_CLEAR_ALL) begin
					free_q       <= '0;
					sweep_pend_q <= 1'b1;
				end
			end
			if (state_q == S_SWEEP) begin
				sweep_q <= sweep_q + CELL_W'(1);
				if (sweep_q == CELL_W'(NCELLS - 1)) begin
					sweep_q      <= '0;
					sweep_pend_q <= 1'b0;
				end
			end
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd_q  <= cmd_t'(s_tdata[1:0]);
					cell_q <= CELL_W'(cell_full);
					id_q   <= s_tdata[45:14];
					idx_q  <= s_tdata[57:46];
				end
			end
			S_EXEC: begin
				res_status_q <= STAT_OK;
				res_count_q  <= cnt_rd;
				res_id_q     <= '0;
				nc_q         <= nc;
				last_q       <= last_rd;
				ch_q         <= LNK_W'(first_rd);
				rem_q        <= idx_q - IDX_W'(DENSE_SLOTS);
				sel_pool_q   <= (idx_q >= IDX_W'(DENSE_SLOTS));
				case (cmd_q)
					CMD_APPEND: begin
						if (cnt_rd >= CNT_W'(DENSE_SLOTS) && need_chunk && free_q >= NIL) begin
							res_status_q <= STAT_POOL_FULL;
						end else begin
							res_count_q <= cnt_rd + CNT_W'(1);
						end
					end
					CMD_READ: begin
						if (idx_q >= cnt_rd) begin
							res_status_q <= STAT_BAD_INDEX;
						end
					end
					default: res_count_q <= '0;
				endcase
			end
			S_WALK: begin
				if (rem_q >= IDX_W'(CHUNK_LEN)) begin
					rem_q <= rem_q - IDX_W'(CHUNK_LEN);
				end
			end
			S_WALK_WAIT: ch_q <= lnk_rd;
			S_DATA: res_id_q <= sel_pool_q ? pool_rd : dense_rd;
			S_OUT: begin
				if (out_free) begin
					m_tdata_q <= {2'b00, res_id_q, res_count_q, res_status_q};
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
